// ===== hdl/cta_pkg.sv =====
// types, constants and ratio helpers for the color-to-alpha pixel core
// no dependencies
package cta_pkg;

	localparam int CHANNELS = 3;
	localparam int LANES    = 4;
	localparam int QBITS    = 8;
	localparam logic [7:0] CHAN_MAX  = 8'd255;
	localparam logic [23:0] KEY_RESET = 24'hFFFFFF;

	typedef struct packed {
		logic [7:0] num;
		logic [7:0] den;
	} ratio_t;

	// distance of one channel from its key, as an exact fraction
	function automatic ratio_t channel_ratio(input logic [7:0] s, input logic [7:0] k);
		ratio_t r;
		if (k == 8'd0) begin
			r.num = s;
			r.den = CHAN_MAX;
		end else if (s > k) begin
			r.num = s - k;
			r.den = CHAN_MAX - k;
		end else if (s < k) begin
			r.num = k - s;
			r.den = k;
		end else begin
			r.num = 8'd0;
			r.den = 8'd1;
		end
		return r;
	endfunction

	// a > b by cross multiplication
	function automatic logic frac_greater(input ratio_t a, input ratio_t b);
		logic [15:0] pa;
		logic [15:0] pb;
		pa = a.num * b.den;
		pb = b.num * a.den;
		return pa > pb;
	endfunction

endpackage

// ===== hdl/color_to_alpha_pixel_core.sv =====
// color-to-alpha pixel core: turns a configured key color into transparency
// depends on cta_pkg
//
// usage
//  - pixel channel: a transfer happens at a clock edge with start high and
//    busy low; busy is always low, so one pixel can enter every cycle
//  - result channel: done is high for exactly one cycle with out_* valid;
//    the receiver takes it at the edge ending that cycle and cannot stall
//  - key channel: cfg_data is written to the key on cfg_valid && cfg_ready;
//    cfg_ready is always high; write it only while no pixel is in flight
//  - throughput is one pixel per cycle
//  - stage 1 forms the three channel ratios, stage 2 picks the largest by
//    cross multiplication, stage 3 forms the dividends and divisors, stage 4
//    checks saturation, stages 5..12 each retire one quotient bit in four
//    parallel restoring dividers (three colors and alpha)
//  - reset clears all valid bits and loads the key with white
module color_to_alpha_pixel_core
	import cta_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  in_blue,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_alpha,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data,
	output logic        done,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_green,
	output logic [7:0]  out_red,
	output logic [7:0]  out_alpha
);

	logic [23:0] key_color_q;
	logic [7:0]  key [CHANNELS];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	assign key[0] = key_color_q[7:0];
	assign key[1] = key_color_q[15:8];
	assign key[2] = key_color_q[23:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_color_q <= KEY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			key_color_q <= cfg_data;
		end
	end

	// stage 1: channel ratios
	logic       vld_s1;
	logic [7:0] src_s1 [CHANNELS];
	logic [7:0] alpha_s1;
	ratio_t     rat_s1 [CHANNELS];
	logic [7:0] src_in [CHANNELS];

	assign src_in[0] = in_blue;
	assign src_in[1] = in_green;
	assign src_in[2] = in_red;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < CHANNELS; c++) begin
			src_s1[c] <= src_in[c];
			rat_s1[c] <= channel_ratio(src_in[c], key[c]);
		end
		alpha_s1 <= in_alpha;
	end

	// stage 2: largest ratio; on a tie blue wins over green and red, green over red
	logic       vld_s2;
	logic [7:0] src_s2 [CHANNELS];
	logic [7:0] alpha_s2;
	ratio_t     amax_s2;
	ratio_t     amax;

	always_comb begin
		if (frac_greater(rat_s1[2], rat_s1[1])) begin
			amax = frac_greater(rat_s1[2], rat_s1[0]) ? rat_s1[2] : rat_s1[0];
		end else begin
			amax = frac_greater(rat_s1[1], rat_s1[0]) ? rat_s1[1] : rat_s1[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		src_s2   <= src_s1;
		alpha_s2 <= alpha_s1;
		amax_s2  <= amax;
	end

	// stage 3: dividend 2x+y and divisor 2y for each lane
	// lanes 0..2 unkey the colors, lane 3 scales alpha
	// a zero maximum turns a color lane into (2s+1)/2 so the color passes
	logic        vld_s3;
	logic [17:0] dvd_s3 [LANES];
	logic [8:0]  dvs_s3 [LANES];
	logic [17:0] dvd    [LANES];
	logic [8:0]  dvs    [LANES];
	logic [15:0] kn     [CHANNELS];
	logic signed [8:0]  diff [CHANNELS];
	logic signed [17:0] dp   [CHANNELS];
	logic signed [19:0] tx   [CHANNELS];
	logic [15:0] na;

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			kn[c]   = key[c] * amax_s2.num;
			diff[c] = $signed({1'b0, src_s2[c]}) - $signed({1'b0, key[c]});
			dp[c]   = diff[c] * $signed({1'b0, amax_s2.den});
			tx[c]   = (($signed({4'b0, kn[c]}) + $signed({{2{dp[c][17]}}, dp[c]})) <<< 1)
				+ $signed({12'b0, amax_s2.num});
			if (amax_s2.num == 8'd0) begin
				dvd[c] = {9'b0, src_s2[c], 1'b1};
				dvs[c] = 9'd2;
			end else begin
				dvd[c] = tx[c][19] ? 18'd0 : tx[c][17:0];
				dvs[c] = {amax_s2.num, 1'b0};
			end
		end
		na           = amax_s2.num * alpha_s2;
		dvd[LANES-1] = {1'b0, na, 1'b0} + {10'b0, amax_s2.den};
		dvs[LANES-1] = {amax_s2.den, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		dvd_s3 <= dvd;
		dvs_s3 <= dvs;
	end

	// stage 4 and the bit stages: index 0 is stage 4, index QBITS is stage 12
	logic              vld_sx [QBITS+1];
	logic [16:0]       rem_sx [QBITS+1][LANES];
	logic [QBITS-1:0]  quo_sx [QBITS+1][LANES];
	logic              sat_sx [QBITS+1][LANES];
	logic [8:0]        dvs_sx [QBITS+1][LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= QBITS; j++) begin
				vld_sx[j] <= 1'b0;
			end
		end else begin
			vld_sx[0] <= vld_s3;
			for (int j = 1; j <= QBITS; j++) begin
				vld_sx[j] <= vld_sx[j-1];
			end
		end
	end

	// quotient of 256 or more saturates
	// each bit stage tries the divisor shifted to its quotient bit
	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			sat_sx[0][l] <= dvd_s3[l][17:8] >= {1'b0, dvs_s3[l]};
			rem_sx[0][l] <= dvd_s3[l][16:0];
			quo_sx[0][l] <= '0;
			dvs_sx[0][l] <= dvs_s3[l];
		end
		for (int j = 1; j <= QBITS; j++) begin
			for (int l = 0; l < LANES; l++) begin
				sat_sx[j][l] <= sat_sx[j-1][l];
				dvs_sx[j][l] <= dvs_sx[j-1][l];
				if (rem_sx[j-1][l] >= ({8'b0, dvs_sx[j-1][l]} << (QBITS - j))) begin
					rem_sx[j][l] <= rem_sx[j-1][l] - ({8'b0, dvs_sx[j-1][l]} << (QBITS - j));
					quo_sx[j][l] <= quo_sx[j-1][l] | (QBITS'(1) << (QBITS - j));
				end else begin
					rem_sx[j][l] <= rem_sx[j-1][l];
					quo_sx[j][l] <= quo_sx[j-1][l];
				end
			end
		end
	end

	assign done      = vld_sx[QBITS];
	assign out_blue  = sat_sx[QBITS][0] ? CHAN_MAX : quo_sx[QBITS][0];
	assign out_green = sat_sx[QBITS][1] ? CHAN_MAX : quo_sx[QBITS][1];
	assign out_red   = sat_sx[QBITS][2] ? CHAN_MAX : quo_sx[QBITS][2];
	assign out_alpha = sat_sx[QBITS][3] ? CHAN_MAX : quo_sx[QBITS][3];

	// every accepted pixel comes out as a result with done high
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##12 done)
		else $error("pixel result missing");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 12))
		else $error("result without pixel");

	// a pixel equal to the key ends fully transparent
	a_key_clear: assert property (@(posedge clk) disable iff (!arst_n)
		start && in_red == key_color_q[23:16] && in_green == key_color_q[15:8]
		&& in_blue == key_color_q[7:0] |-> ##12 out_alpha == 8'd0)
		else $error("key pixel not transparent");

endmodule

// ===== verif/tb_color_to_alpha_pixel_core.sv =====
// self-checking testbench for color_to_alpha_pixel_core: key color removal per pixel
// depends on cta_pkg and color_to_alpha_pixel_core; predicts results with exact fractions
`timescale 1ns / 100ps

// expected pixels in order, with the key they were computed under
class pixel_scoreboard;
	logic [31:0] pending_pixels[$];
	logic [23:0] key;
	int errors;

	function new();
		key = cta_pkg::KEY_RESET;
		errors = 0;
	endfunction

	// exact rounding half up of x/y, clamped to the channel range
	static function logic [7:0] div_round(longint x, longint y);
		longint t;
		longint q;
		t = 2 * x + y;
		if (t < 0)
			return 8'd0;
		q = t / (2 * y);
		if (q > 255)
			q = 255;
		return q[7:0];
	endfunction

	static function void ratio_of(longint s, longint k, output longint n, output longint d);
		if (k == 0) begin
			n = s;
			d = 255;
		end else if (s > k) begin
			n = s - k;
			d = 255 - k;
		end else if (s < k) begin
			n = k - s;
			d = k;
		end else begin
			n = 0;
			d = 1;
		end
	endfunction

	// alpha fraction and un-keyed channels for one pixel, packed a,r,g,b
	function logic [31:0] unkey_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r,
			logic [7:0] a);
		longint s[3];
		longint k[3];
		longint n[3];
		longint d[3];
		longint an;
		longint ad;
		logic [7:0] o[3];
		s[0] = r; s[1] = g; s[2] = b;
		k[0] = key[23:16]; k[1] = key[15:8]; k[2] = key[7:0];
		for (int i = 0; i < 3; i++)
			ratio_of(s[i], k[i], n[i], d[i]);
		// same tie order as the hardware: red over green only if strictly greater
		if (n[0] * d[1] > n[1] * d[0]) begin
			if (n[0] * d[2] > n[2] * d[0]) begin
				an = n[0]; ad = d[0];
			end else begin
				an = n[2]; ad = d[2];
			end
		end else if (n[1] * d[2] > n[2] * d[1]) begin
			an = n[1]; ad = d[1];
		end else begin
			an = n[2]; ad = d[2];
		end
		// pixel equal to key: colors pass, fully transparent
		if (an == 0)
			return {8'd0, r, g, b};
		for (int i = 0; i < 3; i++)
			o[i] = div_round(k[i] * an + (s[i] - k[i]) * ad, an);
		return {div_round(an * a, ad), o[0], o[1], o[2]};
	endfunction

	function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic [7:0] a);
		pending_pixels.push_back(unkey_pixel(b, g, r, a));
	endfunction

	function void check_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic [7:0] a);
		logic [31:0] want;
		if (pending_pixels.size() == 0) begin
			$display("%0t: unexpected result argb=%h", $time, {a, r, g, b});
			errors++;
			return;
		end
		want = pending_pixels.pop_front();
		if (want[31:24] !== a) begin
			$display("%0t: out_alpha expected %0d actual %0d", $time, want[31:24], a);
			errors++;
		end
		if (want[23:16] !== r) begin
			$display("%0t: out_red expected %0d actual %0d", $time, want[23:16], r);
			errors++;
		end
		if (want[15:8] !== g) begin
			$display("%0t: out_green expected %0d actual %0d", $time, want[15:8], g);
			errors++;
		end
		if (want[7:0] !== b) begin
			$display("%0t: out_blue expected %0d actual %0d", $time, want[7:0], b);
			errors++;
		end
	endfunction
endclass

module tb_color_to_alpha_pixel_core;
	import cta_pkg::*;

	localparam int LATENCY = 12;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [7:0]  in_blue;
	logic [7:0]  in_green;
	logic [7:0]  in_red;
	logic [7:0]  in_alpha;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [23:0] cfg_data;
	logic        done;
	logic [7:0]  out_blue;
	logic [7:0]  out_green;
	logic [7:0]  out_red;
	logic [7:0]  out_alpha;

	pixel_scoreboard sb;
	// idle chance in percent; zero during the no-gap stretch
	int idle_pct;

	color_to_alpha_pixel_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_blue(in_blue), .in_green(in_green), .in_red(in_red), .in_alpha(in_alpha),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .out_blue(out_blue), .out_green(out_green),
		.out_red(out_red), .out_alpha(out_alpha)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// result monitor: done is a one-cycle strobe, sampled at the edge ending it
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_pixel(out_blue, out_green, out_red, out_alpha);
	end

	// one pixel transfer, with a random gap first; start stays high across back-to-back pixels
	task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic [7:0] a);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		in_blue  <= b;
		in_green <= g;
		in_red   <= r;
		in_alpha <= a;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_pixel(b, g, r, a);
	endtask

	// hold the pixel side until nothing is in flight, then let the pipe empty
	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_pixels.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// key write: only with the pipe empty
	task automatic write_key(logic [23:0] k);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= k;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.key = k;
		@(posedge clk);
	endtask

	// pixel near the key most of the time, so ratios tie and stay small
	function automatic logic [7:0] near_key(logic [7:0] k);
		int v;
		if ($urandom_range(3) == 0)
			return 8'($urandom_range(255));
		v = int'(k) + $urandom_range(8) - 4;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return v[7:0];
	endfunction

	task automatic random_burst(int count);
		for (int i = 0; i < count; i++) begin
			// no gaps at all in the middle of the phase
			idle_pct = (i > count / 3 && i < count / 2) ? 0 : 32;
			send_pixel(near_key(sb.key[7:0]), near_key(sb.key[15:8]),
				near_key(sb.key[23:16]), 8'($urandom_range(255)));
		end
	endtask

	initial begin
		logic [23:0] keys[6];
		sb = new();
		arst_n    = 1'b0;
		start     = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		in_blue   = '0;
		in_green  = '0;
		in_red    = '0;
		in_alpha  = '0;
		idle_pct  = 32;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset key is white
		send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF); // pixel equal to key
		send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
		send_pixel(8'h00, 8'h00, 8'h00, 8'hFF);
		send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
		send_pixel(8'h80, 8'hFF, 8'h7F, 8'h01);
		send_pixel(8'h55, 8'hAA, 8'h01, 8'hFE);
		// black key: every ratio is s/255
		write_key(24'h000000);
		send_pixel(8'h00, 8'h00, 8'h00, 8'hFF);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'h01, 8'h80, 8'hFE, 8'h7F);
		send_pixel(8'h40, 8'h40, 8'h40, 8'h80);
		// mixed key: one zero channel, one full, one mid
		write_key(24'h00FF80);
		send_pixel(8'h80, 8'hFF, 8'h00, 8'hAA); // equal to key
		send_pixel(8'h81, 8'hFE, 8'h01, 8'hFF);
		send_pixel(8'hFF, 8'h00, 8'hFF, 8'h55);
		send_pixel(8'h00, 8'h01, 8'h80, 8'h33);
		send_pixel(8'h7F, 8'hFF, 8'h00, 8'hFF);

		keys[0] = 24'hFFFFFF;
		keys[1] = 24'h000000;
		keys[2] = 24'h010101;
		keys[3] = 24'hFEFEFE;
		keys[4] = 24'h123456;
		keys[5] = 24'hA5005A;
		for (int p = 0; p < 6; p++) begin
			write_key(keys[p]);
			random_burst(200);
		end
		for (int p = 0; p < 4; p++) begin
			write_key(24'($urandom_range(24'hFFFFFF)));
			random_burst(185);
		end
		drain();

		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#3000000;
		$display("status: fail");
		$finish;
	end
endmodule
